// ----- hdl/wst_pkg.sv -----
// shared types, constants and codes of the wildcard session table
`timescale 1ns / 1ps

package wst_pkg;

    // default table depth
    localparam int DEFAULT_TABLE_ENTRIES = 16;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes
    localparam logic [1:0] REG_ACTIVE_ENTRIES   = 2'd0;
    localparam logic [1:0] REG_PORT_WILDCARD    = 2'd1;
    localparam logic [1:0] REG_ADDRESS_WILDCARD = 2'd2;
    localparam logic [1:0] REG_IPV4_MASK        = 2'd3;

    // register reset values
    localparam logic [4:0]  RST_ACTIVE_ENTRIES   = 5'd16;
    localparam logic [15:0] RST_PORT_WILDCARD    = 16'd0;
    localparam logic [31:0] RST_ADDRESS_WILDCARD = 32'd0;
    localparam logic [7:0]  RST_IPV4_MASK        = 8'd1;

    // action codes
    localparam logic [1:0] ACT_ALLOCATE = 2'd0;
    localparam logic [1:0] ACT_BIND     = 2'd1;
    localparam logic [1:0] ACT_LOOKUP   = 2'd2;

    typedef struct packed {
        logic [4:0]  active_entries;
        logic [15:0] port_wildcard;
        logic [31:0] address_wildcard;
        logic [7:0]  ipv4_mask;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [7:0]  local_protocol;
        logic [15:0] local_port;
        logic [31:0] local_address;
        logic [7:0]  remote_protocol;
        logic [15:0] remote_port;
        logic [31:0] remote_address;
    } entry_t;

endpackage

// ----- hdl/wst_ctrl.sv -----
// sequencing state machine of the wildcard session table
`timescale 1ns / 1ps

module wst_ctrl
    import wst_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.scan    = 1'b0;
        cmd.finish  = 1'b0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for room in the result register
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/wst_datapath.sv -----
// entry store, scan pipeline and result register of the wildcard session table
`timescale 1ns / 1ps

module wst_datapath
    import wst_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [1:0]  s_action,
    input  logic [3:0]  s_slot_index,
    input  logic [7:0]  s_local_protocol,
    input  logic [15:0] s_local_port,
    input  logic [31:0] s_local_ip_address,
    input  logic [7:0]  s_remote_protocol,
    input  logic [15:0] s_remote_port,
    input  logic [31:0] s_remote_ip_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_success,
    output logic [3:0]  m_entry_index
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    function automatic logic sides_match(
        input logic [7:0]  pa,
        input logic [15:0] porta,
        input logic [31:0] aa,
        input logic [7:0]  pb,
        input logic [15:0] portb,
        input logic [31:0] ab,
        input cfg_t        c
    );
        logic port_ok;
        logic prot_ok;
        logic addr_ok;
        port_ok = (porta == c.port_wildcard) || (portb == c.port_wildcard) || (porta == portb);
        prot_ok = ((pa & c.ipv4_mask) != 8'd0) && ((pb & c.ipv4_mask) != 8'd0);
        addr_ok = (aa == c.address_wildcard) || (ab == c.address_wildcard) || (aa == ab);
        return port_ok && prot_ok && addr_ok;
    endfunction

    // captured item
    logic [1:0]  act_reg;
    logic [3:0]  slot_reg;
    logic [7:0]  lprot_reg;
    logic [15:0] lport_reg;
    logic [31:0] laddr_reg;
    logic [7:0]  rprot_reg;
    logic [15:0] rport_reg;
    logic [31:0] raddr_reg;

    // entry store and its per-entry flags
    entry_t                   mem [TABLE_ENTRIES];
    entry_t                   rd_data_reg;
    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [TABLE_ENTRIES-1:0] written_reg;

    // scan pipeline
    logic [CNT_W-1:0] addr_reg;
    logic             cand_valid_reg;
    logic [IDX_W-1:0] cand_idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;

    // result register
    logic       m_valid_reg;
    logic       m_success_reg;
    logic [3:0] m_index_reg;

    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] lim_eff;
    logic             issue;
    logic             cand_match;
    entry_t           stored;
    logic             bind_ok;
    logic             res_success;
    logic [3:0]       res_index;

    always_comb begin
        if (32'(cfg.active_entries) > 32'(TABLE_ENTRIES)) begin
            lim = CNT_W'(TABLE_ENTRIES);
        end else begin
            lim = CNT_W'(cfg.active_entries);
        end
        if (act_reg == ACT_ALLOCATE || act_reg == ACT_LOOKUP) begin
            lim_eff = lim;
        end else begin
            lim_eff = '0;
        end
    end

    assign issue   = cmd.scan && !hit_reg && (addr_reg < lim_eff);
    assign bind_ok = 32'(slot_reg) < 32'(TABLE_ENTRIES);

    // never written entries read as all zero
    assign stored = written_reg[cand_idx_reg] ? rd_data_reg : '0;

    always_comb begin
        case (act_reg)
            ACT_ALLOCATE: cand_match = !used_reg[cand_idx_reg];
            ACT_LOOKUP:   cand_match = used_reg[cand_idx_reg]
                && sides_match(rprot_reg, rport_reg, raddr_reg, stored.remote_protocol,
                               stored.remote_port, stored.remote_address, cfg)
                && sides_match(lprot_reg, lport_reg, laddr_reg, stored.local_protocol,
                               stored.local_port, stored.local_address, cfg);
            default:      cand_match = 1'b0;
        endcase
    end

    assign status.scan_done = hit_reg || (!cand_valid_reg && !(addr_reg < lim_eff));
    assign status.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg   <= s_action;
            slot_reg  <= s_slot_index;
            lprot_reg <= s_local_protocol;
            lport_reg <= s_local_port;
            laddr_reg <= s_local_ip_address;
            rprot_reg <= s_remote_protocol;
            rport_reg <= s_remote_port;
            raddr_reg <= s_remote_ip_address;
        end
    end

    // store: one write port for bind, one registered read port for the scan
    always_ff @(posedge aclk) begin
        if (cmd.finish && act_reg == ACT_BIND && bind_ok) begin
            mem[IDX_W'(slot_reg)] <= '{
                local_protocol:  lprot_reg,
                local_port:      lport_reg,
                local_address:   laddr_reg,
                remote_protocol: lprot_reg,
                remote_port:     cfg.port_wildcard,
                remote_address:  cfg.address_wildcard
            };
        end
        if (issue) begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            written_reg <= '0;
        end else if (cmd.finish) begin
            if (act_reg == ACT_ALLOCATE && hit_reg) begin
                used_reg[hit_idx_reg] <= 1'b1;
            end
            if (act_reg == ACT_BIND && bind_ok) begin
                written_reg[IDX_W'(slot_reg)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg       <= '0;
            cand_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
        end else if (cmd.capture) begin
            addr_reg       <= '0;
            cand_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
        end else if (cmd.scan) begin
            cand_valid_reg <= issue;
            if (issue) begin
                addr_reg <= addr_reg + CNT_W'(1);
            end
            if (cand_valid_reg && !hit_reg && cand_match) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            cand_idx_reg <= addr_reg[IDX_W-1:0];
        end
        if (cmd.scan && cand_valid_reg && !hit_reg && cand_match) begin
            hit_idx_reg <= cand_idx_reg;
        end
    end

    always_comb begin
        res_success = 1'b0;
        res_index   = 4'd0;
        case (act_reg)
            ACT_ALLOCATE, ACT_LOOKUP: begin
                if (hit_reg) begin
                    res_success = 1'b1;
                    res_index   = 4'(hit_idx_reg);
                end
            end
            ACT_BIND: begin
                if (bind_ok) begin
                    res_success = 1'b1;
                    res_index   = slot_reg;
                end
            end
            default: begin
                res_success = 1'b0;
                res_index   = 4'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_success_reg <= res_success;
            m_index_reg   <= res_index;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_success     = m_success_reg;
    assign m_entry_index = m_index_reg;

endmodule

// ----- hdl/wildcard_session_table_unit.sv -----
// top level of the wildcard session table: configuration registers and unit wiring
`timescale 1ns / 1ps

// session table with wildcard matching of ports and ipv4 addresses
// - input channel (s_*): one beat is one command: allocate, bind or lookup
// - result channel (m_*): one beat per command, success flag and entry index
// - apb port: four registers at byte addresses 0, 4, 8 and 12; the user must
//   write them only while the table is idle, the block does not enforce it;
//   pready tied high, prdata returns the register value
// - bind and unused codes skip the scan; allocate and lookup scan
//   min(active_entries, TABLE_ENTRIES) entries
// - the next command is accepted only once the controller is back in idle,
//   after the result of the last one is written
// - the scan reads one entry per cycle through the store's single registered
//   read port, and stops at the first hit
// - one command at a time; the next is accepted while a result still waits
// - a stalled receiver holds the result register; a following command is
//   scanned but not finished until that beat has gone
// - reset (aresetn low, synchronous) clears used and written flags, so the
//   table reads as all zero, and restores the register defaults; no clearing
//   pass is needed
module wildcard_session_table_unit
    import wst_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // command channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic [3:0]            s_slot_index,
    input  logic [7:0]            s_local_protocol,
    input  logic [15:0]           s_local_port,
    input  logic [31:0]           s_local_ip_address,
    input  logic [7:0]            s_remote_protocol,
    input  logic [15:0]           s_remote_port,
    input  logic [31:0]           s_remote_ip_address,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_success,
    output logic [3:0]            m_entry_index,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg_reg;
    cmd_t       cmd;
    status_t    status;
    logic       cfg_wr;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    // register writes, one per access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_entries   <= RST_ACTIVE_ENTRIES;
            cfg_reg.port_wildcard    <= RST_PORT_WILDCARD;
            cfg_reg.address_wildcard <= RST_ADDRESS_WILDCARD;
            cfg_reg.ipv4_mask        <= RST_IPV4_MASK;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_ACTIVE_ENTRIES:   cfg_reg.active_entries   <= pwdata[4:0];
                REG_PORT_WILDCARD:    cfg_reg.port_wildcard    <= pwdata[15:0];
                REG_ADDRESS_WILDCARD: cfg_reg.address_wildcard <= pwdata[31:0];
                REG_IPV4_MASK:        cfg_reg.ipv4_mask        <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // read-back mux
    always_comb begin
        case (reg_sel)
            REG_ACTIVE_ENTRIES:   prdata = APB_DATA_W'(cfg_reg.active_entries);
            REG_PORT_WILDCARD:    prdata = APB_DATA_W'(cfg_reg.port_wildcard);
            REG_ADDRESS_WILDCARD: prdata = APB_DATA_W'(cfg_reg.address_wildcard);
            REG_IPV4_MASK:        prdata = APB_DATA_W'(cfg_reg.ipv4_mask);
            default:              prdata = '0;
        endcase
    end

    // sequencer
    wst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // entry store, scan and result register
    wst_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .cmd                 (cmd),
        .status              (status),
        .s_action            (s_action),
        .s_slot_index        (s_slot_index),
        .s_local_protocol    (s_local_protocol),
        .s_local_port        (s_local_port),
        .s_local_ip_address  (s_local_ip_address),
        .s_remote_protocol   (s_remote_protocol),
        .s_remote_port       (s_remote_port),
        .s_remote_ip_address (s_remote_ip_address),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_success           (m_success),
        .m_entry_index       (m_entry_index)
    );

endmodule

// ----- tb/sv/wst_session_checker.sv -----
// session table checker: snoops the beats and registers, predicts each reply and compares
`timescale 1ns / 1ps

module wst_session_checker
    import wst_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic [3:0]            s_slot_index,
    input  logic [7:0]            s_local_protocol,
    input  logic [15:0]           s_local_port,
    input  logic [31:0]           s_local_ip_address,
    input  logic [7:0]            s_remote_protocol,
    input  logic [15:0]           s_remote_port,
    input  logic [31:0]           s_remote_ip_address,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_success,
    input  logic [3:0]            m_entry_index,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    fault_count,
    output int                    replies_due
);

    typedef struct packed {
        logic       success;
        logic [3:0] index;
    } reply_t;

    cfg_t   settings;
    logic   slot_taken [TABLE_ENTRIES];
    entry_t slot_data  [TABLE_ENTRIES];
    reply_t awaited_replies [$];
    int     faults = 0;

    // port, protocol and address rules of one side pair
    function automatic logic sides_agree(input logic [7:0] proto_a, input logic [15:0] port_a,
                                         input logic [31:0] addr_a, input logic [7:0] proto_b,
                                         input logic [15:0] port_b, input logic [31:0] addr_b);
        logic port_ok;
        logic proto_ok;
        logic addr_ok;
        port_ok  = (port_a == settings.port_wildcard) || (port_b == settings.port_wildcard) ||
                   (port_a == port_b);
        proto_ok = (|(proto_a & settings.ipv4_mask)) && (|(proto_b & settings.ipv4_mask));
        addr_ok  = (addr_a == settings.address_wildcard) ||
                   (addr_b == settings.address_wildcard) || (addr_a == addr_b);
        return port_ok && proto_ok && addr_ok;
    endfunction

    // applies one command to the table copy and returns its reply
    function automatic reply_t table_reply(input logic [1:0] action, input logic [3:0] slot,
                                           input logic [7:0] lproto, input logic [15:0] lport,
                                           input logic [31:0] laddr, input logic [7:0] rproto,
                                           input logic [15:0] rport, input logic [31:0] raddr);
        reply_t r;
        int     lim;
        int     i;
        r   = '0;
        lim = (int'(settings.active_entries) > TABLE_ENTRIES) ? TABLE_ENTRIES
                                                               : int'(settings.active_entries);
        case (action)
            ACT_ALLOCATE: begin
                for (i = 0; i < lim && !r.success; i++) begin
                    if (!slot_taken[i]) begin
                        slot_taken[i] = 1'b1;
                        r.success     = 1'b1;
                        r.index       = i[3:0];
                    end
                end
            end
            ACT_BIND: begin
                if (int'(slot) < TABLE_ENTRIES) begin
                    slot_data[slot].local_protocol  = lproto;
                    slot_data[slot].local_port      = lport;
                    slot_data[slot].local_address   = laddr;
                    slot_data[slot].remote_protocol = lproto;
                    slot_data[slot].remote_port     = settings.port_wildcard;
                    slot_data[slot].remote_address  = settings.address_wildcard;
                    r.success = 1'b1;
                    r.index   = slot;
                end
            end
            ACT_LOOKUP: begin
                for (i = 0; i < lim && !r.success; i++) begin
                    if (slot_taken[i] &&
                        sides_agree(rproto, rport, raddr, slot_data[i].remote_protocol,
                                    slot_data[i].remote_port, slot_data[i].remote_address) &&
                        sides_agree(lproto, lport, laddr, slot_data[i].local_protocol,
                                    slot_data[i].local_port, slot_data[i].local_address)) begin
                        r.success = 1'b1;
                        r.index   = i[3:0];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            settings.active_entries   = RST_ACTIVE_ENTRIES;
            settings.port_wildcard    = RST_PORT_WILDCARD;
            settings.address_wildcard = RST_ADDRESS_WILDCARD;
            settings.ipv4_mask        = RST_IPV4_MASK;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_taken[i] = 1'b0;
                slot_data[i]  = '0;
            end
            awaited_replies.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ACTIVE_ENTRIES:   settings.active_entries   = pwdata[4:0];
                    REG_PORT_WILDCARD:    settings.port_wildcard    = pwdata[15:0];
                    REG_ADDRESS_WILDCARD: settings.address_wildcard = pwdata[31:0];
                    REG_IPV4_MASK:        settings.ipv4_mask        = pwdata[7:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    faults++;
                    $display("%0t: reply beat with none expected: success %0b index %0d",
                             $time, m_success, m_entry_index);
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_success !== want.success) begin
                        faults++;
                        $display("%0t: success expected %0b, got %0b",
                                 $time, want.success, m_success);
                    end
                    if (m_entry_index !== want.index) begin
                        faults++;
                        $display("%0t: entry_index expected %0d, got %0d",
                                 $time, want.index, m_entry_index);
                    end
                end
            end
            if (s_valid && s_ready)
                awaited_replies.push_back(table_reply(s_action, s_slot_index, s_local_protocol,
                                                      s_local_port, s_local_ip_address,
                                                      s_remote_protocol, s_remote_port,
                                                      s_remote_ip_address));
        end
        fault_count <= faults;
        replies_due <= awaited_replies.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
// top of the session table bench: clock, reset, command and register stimulus, verdict
`timescale 1ns / 1ps

module tb;
    import wst_pkg::*;

    // the one action code the block does not define
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;

    // command channel, all driven from the first step
    logic                  s_valid             = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_action            = '0;
    logic [3:0]            s_slot_index        = '0;
    logic [7:0]            s_local_protocol    = '0;
    logic [15:0]           s_local_port        = '0;
    logic [31:0]           s_local_ip_address  = '0;
    logic [7:0]            s_remote_protocol   = '0;
    logic [15:0]           s_remote_port       = '0;
    logic [31:0]           s_remote_ip_address = '0;

    // reply channel
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    logic                  m_success;
    logic [3:0]            m_entry_index;

    // register port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fault_count;
    int                    replies_due;

    // idle chances in percent per beat (sender) and per cycle (receiver)
    int                    gap_pct     = 0;
    int                    burst_pct   = 0;
    int                    hold_cycles = 0;

    // register values last written, used to steer stimulus towards hits
    logic [15:0]           cur_port_wc = RST_PORT_WILDCARD;
    logic [31:0]           cur_addr_wc = RST_ADDRESS_WILDCARD;
    logic [7:0]            cur_mask    = RST_IPV4_MASK;

    // what each slot was last bound with, so lookups can aim at real entries
    logic [7:0]            bound_proto [16];
    logic [15:0]           bound_port  [16];
    logic [31:0]           bound_addr  [16];
    logic [15:0]           bound_rport [16];
    logic [31:0]           bound_raddr [16];

    always #1 aclk = ~aclk;

    wildcard_session_table_unit u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_slot_index        (s_slot_index),
        .s_local_protocol    (s_local_protocol),
        .s_local_port        (s_local_port),
        .s_local_ip_address  (s_local_ip_address),
        .s_remote_protocol   (s_remote_protocol),
        .s_remote_port       (s_remote_port),
        .s_remote_ip_address (s_remote_ip_address),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_success           (m_success),
        .m_entry_index       (m_entry_index),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    wst_session_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_slot_index        (s_slot_index),
        .s_local_protocol    (s_local_protocol),
        .s_local_port        (s_local_port),
        .s_local_ip_address  (s_local_ip_address),
        .s_remote_protocol   (s_remote_protocol),
        .s_remote_port       (s_remote_port),
        .s_remote_ip_address (s_remote_ip_address),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_success           (m_success),
        .m_entry_index       (m_entry_index),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .pready              (pready),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .fault_count         (fault_count),
        .replies_due         (replies_due)
    );

    // receiver back-pressure: stalls of random length, started at random
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_ready <= (hold_cycles == 0);
        end else if (burst_pct > 0 && $urandom_range(99) < burst_pct) begin
            hold_cycles = $urandom_range(9, 1);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // hard stop in case the block hangs
    initial begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

    // one command beat, with an optional gap before it; returns at the accepting edge
    task automatic issue(input logic [1:0] action, input logic [3:0] slot,
                         input logic [7:0] lproto, input logic [15:0] lport,
                         input logic [31:0] laddr, input logic [7:0] rproto,
                         input logic [15:0] rport, input logic [31:0] raddr);
        int n;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            n = $urandom_range(9, 1);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_action            <= action;
        s_slot_index        <= slot;
        s_local_protocol    <= lproto;
        s_local_port        <= lport;
        s_local_ip_address  <= laddr;
        s_remote_protocol   <= rproto;
        s_remote_port       <= rport;
        s_remote_ip_address <= raddr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // bind, keeping note of what went into the slot
    task automatic bind_slot(input logic [3:0] slot, input logic [7:0] lproto,
                             input logic [15:0] lport, input logic [31:0] laddr,
                             input logic [7:0] rproto, input logic [15:0] rport,
                             input logic [31:0] raddr);
        bound_proto[slot] = lproto;
        bound_port[slot]  = lport;
        bound_addr[slot]  = laddr;
        bound_rport[slot] = cur_port_wc;
        bound_raddr[slot] = cur_addr_wc;
        issue(ACT_BIND, slot, lproto, lport, laddr, rproto, rport, raddr);
    endtask

    // stop sending and wait until every reply is back, so the table is idle
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (replies_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    // apb write: setup cycle then access cycle, register taken at the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_settings(input logic [4:0] active, input logic [15:0] port_wc,
                                  input logic [31:0] addr_wc, input logic [7:0] mask);
        write_reg(REG_ACTIVE_ENTRIES, {27'd0, active});
        write_reg(REG_PORT_WILDCARD, {16'd0, port_wc});
        write_reg(REG_ADDRESS_WILDCARD, addr_wc);
        write_reg(REG_IPV4_MASK, {24'd0, mask});
        cur_port_wc = port_wc;
        cur_addr_wc = addr_wc;
        cur_mask    = mask;
        @(posedge aclk);
    endtask

    // field pickers: mostly values that hit stored entries or the wildcards
    function automatic logic [15:0] pick_port(input logic [15:0] near);
        case ($urandom_range(5))
            0:       return cur_port_wc;
            1, 2:    return near;
            3:       return 16'd80;
            4:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_addr(input logic [31:0] near);
        case ($urandom_range(5))
            0:       return cur_addr_wc;
            1, 2:    return near;
            3:       return 32'hC0A8_0001;
            4:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_proto(input logic [7:0] near);
        logic [7:0] noise;
        noise = 8'($urandom);
        case ($urandom_range(4))
            0, 1:    return near;
            2:       return noise | cur_mask;
            3:       return noise & ~cur_mask;
            default: return noise;
        endcase
    endfunction

    // one random command; slots lean towards the low ones so small active counts see them
    task automatic random_command();
        int         roll;
        int         j;
        int         k;
        logic [3:0] slot;
        roll = $urandom_range(99);
        j    = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(15);
        k    = $urandom_range(15);
        slot = j[3:0];
        if (roll < 12) begin
            // allocate, every other field is noise
            issue(ACT_ALLOCATE, 4'($urandom), 8'($urandom), 16'($urandom), $urandom,
                  8'($urandom), 16'($urandom), $urandom);
        end else if (roll < 45) begin
            // bind, often copying another slot so several entries can match
            bind_slot(slot, pick_proto(bound_proto[k]), pick_port(bound_port[k]),
                      pick_addr(bound_addr[k]), 8'($urandom), 16'($urandom), $urandom);
        end else if (roll < 95) begin
            // lookup aimed at slot j with random deviations per field
            issue(ACT_LOOKUP, 4'($urandom), pick_proto(bound_proto[slot]),
                  pick_port(bound_port[slot]), pick_addr(bound_addr[slot]),
                  pick_proto(bound_proto[slot]), pick_port(bound_rport[slot]),
                  pick_addr(bound_raddr[slot]));
        end else begin
            issue(ACT_UNUSED, 4'($urandom), 8'($urandom), 16'($urandom), $urandom,
                  8'($urandom), 16'($urandom), $urandom);
        end
    endtask

    initial begin
        int phase;
        for (int i = 0; i < 16; i++) begin
            bound_proto[i] = '0;
            bound_port[i]  = '0;
            bound_addr[i]  = '0;
            bound_rport[i] = '0;
            bound_raddr[i] = '0;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct   = 25;
        burst_pct <= 25;

        // directed part under reset register values
        // lookup into an empty table
        issue(ACT_LOOKUP, 4'd0, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0000, 32'h0);
        // unused action code with every field at its top
        issue(ACT_UNUSED, 4'hF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        // allocate ignores every other field
        issue(ACT_ALLOCATE, 4'hF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        issue(ACT_ALLOCATE, 4'h0, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0000, 32'h0);
        // bind ignores the remote fields
        bind_slot(4'd0, 8'h01, 16'd80, 32'h0A00_0001, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        bind_slot(4'd1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'h00, 16'h0000, 32'h0);
        // bind on a slot that was never allocated
        bind_slot(4'd15, 8'h03, 16'd443, 32'hC0A8_0001, 8'h00, 16'h0000, 32'h0);
        // exact local hit, remote side caught by the stored wildcards
        issue(ACT_LOOKUP, 4'd0, 8'h01, 16'd80, 32'h0A00_0001, 8'h01, 16'h1234, 32'h0102_0304);
        issue(ACT_LOOKUP, 4'd0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'h81, 16'hFFFF, 32'hFFFF_FFFF);
        // protocol without the ipv4 bit on the local and then the remote side
        issue(ACT_LOOKUP, 4'd0, 8'hFE, 16'hFFFF, 32'hFFFF_FFFF, 8'h01, 16'hFFFF, 32'hFFFF_FFFF);
        issue(ACT_LOOKUP, 4'd0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'h00, 16'hFFFF, 32'hFFFF_FFFF);
        // wildcard port and address in the query itself
        issue(ACT_LOOKUP, 4'd0, 8'h01, 16'h0000, 32'h0, 8'h01, 16'h0000, 32'h0);
        // bound but unused entry never matches
        issue(ACT_LOOKUP, 4'd0, 8'h03, 16'd443, 32'hC0A8_0001, 8'h03, 16'd443, 32'hC0A8_0001);
        issue(ACT_ALLOCATE, 4'h0, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0000, 32'h0);

        // one active entry: table full, and slot 1 out of reach
        settle();
        write_settings(5'd1, 16'h0000, 32'h0, 8'h01);
        issue(ACT_ALLOCATE, 4'h0, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0000, 32'h0);
        issue(ACT_LOOKUP, 4'd0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'h0000, 32'h0);

        // active count above the table size, all-ones wildcards, top mask bit
        settle();
        write_settings(5'd31, 16'hFFFF, 32'hFFFF_FFFF, 8'h80);
        issue(ACT_ALLOCATE, 4'h0, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0000, 32'h0);
        bind_slot(4'd3, 8'h80, 16'd5, 32'd7, 8'h00, 16'h0000, 32'h0);
        issue(ACT_LOOKUP, 4'd0, 8'h80, 16'hFFFF, 32'hFFFF_FFFF, 8'h80, 16'd9, 32'd9);
        bind_slot(4'd2, 8'h7F, 16'd5, 32'd7, 8'h00, 16'h0000, 32'h0);
        issue(ACT_LOOKUP, 4'd0, 8'h7F, 16'd5, 32'd7, 8'h7F, 16'hFFFF, 32'hFFFF_FFFF);

        // no active entries: allocate and lookup both fail
        settle();
        write_settings(5'd0, 16'h0000, 32'h0, 8'h01);
        issue(ACT_LOOKUP, 4'd0, 8'h01, 16'd80, 32'h0A00_0001, 8'h01, 16'h0000, 32'h0);
        issue(ACT_ALLOCATE, 4'h0, 8'h00, 16'h0000, 32'h0, 8'h00, 16'h0000, 32'h0);

        // random part, a fresh register setting per phase
        for (phase = 0; phase < 8; phase++) begin
            settle();
            case (phase)
                0: write_settings(5'd31, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
                1: write_settings(5'd0, 16'($urandom), $urandom, 8'h00);
                2: write_settings(5'd16, 16'h0000, 32'h0, 8'h01);
                3: write_settings(5'd1, 16'($urandom), $urandom, 8'($urandom));
                4: write_settings(5'($urandom_range(31, 2)), 16'($urandom), $urandom,
                                  8'($urandom));
                5: write_settings(5'd17, 16'($urandom), $urandom, 8'($urandom));
                6: write_settings(5'($urandom_range(31)), 16'h0000, $urandom, 8'($urandom));
                default: write_settings(5'd16, 16'h0000, 32'h0, 8'h01);
            endcase
            // phase 3 runs without idling, the last phase is kept calm too
            if (phase == 3 || phase == 7) begin
                gap_pct   = 0;
                burst_pct <= 0;
            end else begin
                gap_pct   = (phase % 2 == 0) ? 20 : 35;
                burst_pct <= (phase % 2 == 0) ? 20 : 35;
            end
            repeat (75) random_command();
        end

        // drain, then allow for the longest scan
        settle();
        repeat (32) @(posedge aclk);
        if (fault_count == 0 && replies_due == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
